/* rtl/srt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg: shared definitions for the segment reassembly tracker
// Opcode, outcome, error and register index codes, reset values of the
// configuration registers and the layout of one transfer table entry.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam logic [1:0] OP_SEGMENT = 2'd0;
    localparam logic [1:0] OP_FORGET  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [1:0] OUT_NEED  = 2'd0;
    localparam logic [1:0] OUT_DONE  = 2'd1;
    localparam logic [1:0] OUT_REJ   = 2'd2;
    localparam logic [1:0] OUT_HOUSE = 2'd3;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_LIMIT     = 2'd1;
    localparam logic [1:0] ERR_MALFORMED = 2'd2;

    localparam logic [1:0] CFG_MAX_XFER = 2'd0;
    localparam logic [1:0] CFG_MAX_OPEN = 2'd1;
    localparam logic [1:0] CFG_BUDGET   = 2'd2;

    localparam logic [31:0] RST_MAX_XFER = 32'd65536;
    localparam logic [4:0]  RST_MAX_OPEN = 5'd16;
    localparam logic [31:0] RST_BUDGET   = 32'd1048576;

    typedef struct packed {
        logic [15:0] chan;
        logic [31:0] request;
        logic [31:0] total;
        logic [31:0] received;
    } t_slot;

endpackage

/* rtl/segment_reassembly_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_reassembly_tracker: open-transfer table for segmented messages
// Checks each segment header against limits, contiguity, overrun, the arena
// budget and completion: need-more, complete or rejected. Other opcodes report housekeeping.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------
//  input   | i_in_valid / o_in_ready | opcode, channel, tag, flags, offset, sizes
//  output  | o_out_valid/i_out_ready | outcome, error, completed and held bytes
//  config  | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
// Segment headers and forget-channel commands run the key search, which reads
// one table entry per cycle through a single read port; clear and unknown
// opcodes skip the search.
// Reset is synchronous; it clears all valid bits and the held byte count.
// The table entries themselves are not cleared, so there is no clearing pass.
// A stalled output holds the finished result; the next transaction is taken
// once it has been handed to the output register.
// ----------------------------------------------------------------------------
module segment_reassembly_tracker
    import srt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_chan_id,
    input  logic [31:0] i_request_tag,
    input  logic        i_seg_first_flag,
    input  logic        i_seg_more_flag,
    input  logic [31:0] i_seg_start,
    input  logic [31:0] i_declared_total,
    input  logic [15:0] i_payload_bytes,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_outcome,
    output logic [1:0]  o_error_code,
    output logic [31:0] o_completed_length,
    output logic [31:0] o_held_total
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_CHK,
        S_BUD,
        S_COMMIT,
        S_RESP
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [31:0] r_max_xfer;
    logic [4:0]  r_max_open;
    logic [31:0] r_budget;

    // Captured transaction.
    logic [1:0]  r_op;
    logic [15:0] r_ch;
    logic [31:0] r_req;
    logic        r_first;
    logic        r_more;
    logic [31:0] r_off;
    logic [31:0] r_total;
    logic [15:0] r_pay;

    // Table state.
    logic [SLOTS-1:0] r_valid;
    logic [31:0]      r_arena;
    t_slot            r_mem [SLOTS];
    t_slot            r_rd;

    // Scan state.
    logic [CW-1:0] r_idx;
    logic          r_rd_live;
    logic [IW-1:0] r_rd_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [31:0]   r_hit_total;
    logic [31:0]   r_hit_rcv;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_count;

    // Selected entry for the checks.
    logic [IW-1:0] r_s_idx;
    logic [31:0]   r_s_total;
    logic [31:0]   r_s_rcv;
    logic          r_s_new;
    logic [31:0]   r_sum;

    // Pending result.
    logic [1:0]  r_res_outcome;
    logic [1:0]  r_res_err;
    logic [31:0] r_res_len;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_out_outcome;
    logic [1:0]  r_out_err;
    logic [31:0] r_out_len;
    logic [31:0] r_out_held;

    logic          w_issue;
    logic [IW-1:0] w_rd_addr;
    logic          w_mem_we;
    t_slot         w_mem_wdata;
    logic [32:0]   n_sum;
    logic [32:0]   n_budget_sum;
    logic          w_unseg;
    logic          w_lim;

    assign w_issue   = (r_state == S_SCAN) && (r_idx < CW'(SLOTS));
    assign w_rd_addr = r_idx[IW-1:0];
    assign w_mem_we  = (r_state == S_COMMIT) && r_more;

    assign w_mem_wdata.chan     = r_ch;
    assign w_mem_wdata.request  = r_req;
    assign w_mem_wdata.total    = r_s_total;
    assign w_mem_wdata.received = r_sum;

    assign n_sum        = {1'b0, r_s_rcv} + 33'(r_pay);
    assign n_budget_sum = {1'b0, r_arena} + 33'(r_pay);
    assign w_unseg      = !r_first && !r_more && !r_hit;
    assign w_lim        = r_total > r_max_xfer;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_s_idx] <= w_mem_wdata;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_xfer <= RST_MAX_XFER;
            r_max_open <= RST_MAX_OPEN;
            r_budget   <= RST_BUDGET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_XFER: r_max_xfer <= i_cfg_data;
                CFG_MAX_OPEN: r_max_open <= i_cfg_data[4:0];
                CFG_BUDGET:   r_budget   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_arena     <= '0;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op         <= i_opcode;
                        r_ch         <= i_chan_id;
                        r_req        <= i_request_tag;
                        r_first      <= i_seg_first_flag;
                        r_more       <= i_seg_more_flag;
                        r_off        <= i_seg_start;
                        r_total      <= i_declared_total;
                        r_pay        <= i_payload_bytes;
                        r_idx        <= '0;
                        r_rd_live    <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_count      <= '0;
                        r_res_outcome <= OUT_HOUSE;
                        r_res_err     <= ERR_OK;
                        r_res_len     <= '0;
                        unique case (i_opcode) inside
                            OP_SEGMENT, OP_FORGET: r_state <= S_SCAN;
                            OP_CLEAR: begin
                                r_valid <= '0;
                                r_arena <= '0;
                                r_state <= S_RESP;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end

                S_SCAN: begin
                    r_rd_live <= w_issue;
                    r_rd_idx  <= w_rd_addr;
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rd_live) begin
                        if (r_op == OP_FORGET) begin
                            // The forget scan releases each matching entry, one per cycle.
                            if (r_valid[r_rd_idx] && r_rd.chan == r_ch) begin
                                r_arena <= r_arena - r_rd.received;
                                r_valid[r_rd_idx] <= 1'b0;
                            end
                        end else if (r_valid[r_rd_idx]) begin
                            r_count <= r_count + CW'(1);
                            if (!r_hit && r_rd.chan == r_ch && r_rd.request == r_req) begin
                                r_hit       <= 1'b1;
                                r_hit_idx   <= r_rd_idx;
                                r_hit_total <= r_rd.total;
                                r_hit_rcv   <= r_rd.received;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                    end else if (!w_issue) begin
                        r_state <= (r_op == OP_FORGET) ? S_RESP : S_EVAL;
                    end
                end

                S_EVAL: begin
                    if (w_unseg) begin
                        // An unsegmented message never touches the table.
                        r_state <= S_RESP;
                        if (w_lim) begin
                            r_res_outcome <= OUT_REJ;
                            r_res_err     <= ERR_LIMIT;
                        end else if (32'(r_pay) == r_total) begin
                            r_res_outcome <= OUT_DONE;
                            r_res_err     <= ERR_OK;
                            r_res_len     <= r_total;
                        end else begin
                            r_res_outcome <= OUT_REJ;
                            r_res_err     <= ERR_MALFORMED;
                        end
                    end else if (w_lim) begin
                        r_res_outcome <= OUT_REJ;
                        r_res_err     <= ERR_LIMIT;
                        r_state       <= S_RESP;
                    end else if (r_first && !r_hit && r_off == '0) begin
                        if (32'(r_count) >= 32'(r_max_open) || !r_free_found) begin
                            r_res_outcome <= OUT_REJ;
                            r_res_err     <= ERR_LIMIT;
                            r_state       <= S_RESP;
                        end else begin
                            r_s_idx   <= r_free_idx;
                            r_s_total <= r_total;
                            r_s_rcv   <= '0;
                            r_s_new   <= 1'b1;
                            r_state   <= S_CHK;
                        end
                    end else if (!r_first && r_hit && r_total == r_hit_total) begin
                        r_s_idx   <= r_hit_idx;
                        r_s_total <= r_hit_total;
                        r_s_rcv   <= r_hit_rcv;
                        r_s_new   <= 1'b0;
                        r_state   <= S_CHK;
                    end else begin
                        r_res_outcome <= OUT_REJ;
                        r_res_err     <= ERR_MALFORMED;
                        r_state       <= S_RESP;
                    end
                end

                S_CHK: begin
                    if (r_off != r_s_rcv || n_sum > {1'b0, r_s_total}) begin
                        r_arena <= r_arena - r_s_rcv;
                        if (!r_s_new) begin
                            r_valid[r_s_idx] <= 1'b0;
                        end
                        r_res_outcome <= OUT_REJ;
                        r_res_err     <= ERR_MALFORMED;
                        r_state       <= S_RESP;
                    end else begin
                        r_sum   <= n_sum[31:0];
                        r_state <= S_BUD;
                    end
                end

                S_BUD: begin
                    if (n_budget_sum > {1'b0, r_budget}) begin
                        r_arena <= r_arena - r_s_rcv;
                        if (!r_s_new) begin
                            r_valid[r_s_idx] <= 1'b0;
                        end
                        r_res_outcome <= OUT_REJ;
                        r_res_err     <= ERR_LIMIT;
                        r_state       <= S_RESP;
                    end else begin
                        r_state <= S_COMMIT;
                    end
                end

                S_COMMIT: begin
                    r_state <= S_RESP;
                    if (r_more) begin
                        r_arena          <= n_budget_sum[31:0];
                        r_valid[r_s_idx] <= 1'b1;
                        r_res_outcome    <= OUT_NEED;
                        r_res_err        <= ERR_OK;
                    end else begin
                        // The last segment frees the entry whether or not it completes.
                        r_arena <= r_arena - r_s_rcv;
                        if (!r_s_new) begin
                            r_valid[r_s_idx] <= 1'b0;
                        end
                        if (r_sum == r_s_total) begin
                            r_res_outcome <= OUT_DONE;
                            r_res_err     <= ERR_OK;
                            r_res_len     <= r_total;
                        end else begin
                            r_res_outcome <= OUT_REJ;
                            r_res_err     <= ERR_MALFORMED;
                        end
                    end
                end

                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_outcome <= r_res_outcome;
                        r_out_err     <= r_res_err;
                        r_out_len     <= r_res_len;
                        r_out_held    <= r_arena;
                        r_state       <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_out_outcome;
    assign o_error_code       = r_out_err;
    assign o_completed_length = r_out_len;
    assign o_held_total       = r_out_held;

endmodule

/* rtl/srt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_checker: port-level checks for the segment reassembly tracker
// Watches the handshakes and the consistency of the reported result fields.
// ----------------------------------------------------------------------------
module srt_checker
    import srt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_outcome,
    input logic [1:0]  o_error_code,
    input logic [31:0] o_completed_length
);

    // A stalled result stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Accepting a transaction leaves the idle state, so ready is low in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted transaction");

    // Only a rejection carries an error code.
    a_err_iff_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_outcome == OUT_REJ) == (o_error_code != ERR_OK)))
        else $error("error code does not match outcome");

    // A length is reported only for a completed transfer.
    a_len_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome != OUT_DONE |-> o_completed_length == '0)
        else $error("length reported without completion");

endmodule

bind segment_reassembly_tracker srt_checker u_srt_checker (.*);
